// File: rtl/segip_pkg.sv
// Package for the segment intersection block: result kinds, register
// indexes and the fixed-point constants of the parameter division.
// No dependencies.
package segip_pkg;

   localparam int PARAM_SHIFT = 30;
   localparam int FRAC_W      = PARAM_SHIFT + 1;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_CROSS_TOL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COORD_TOL = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PARAM_TOL = 2'd2;

   localparam logic [1:0] KIND_NONE      = 2'd0;
   localparam logic [1:0] KIND_CROSS     = 2'd1;
   localparam logic [1:0] KIND_COLLINEAR = 2'd2;

endpackage

// File: rtl/segip_cell.sv
// One cell of the divider chain: one step of each parameter division (in
// cells with IDX below PARAM_SHIFT; later cells hold them) and one step of the
// collinear restoring division, with a side payload. Depends on segip_pkg.
module segip_cell
   import segip_pkg::*;
#(
   parameter int W      = 32,
   parameter int IDX    = 0,
   parameter int SIDE_W = 8
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                valid_i,
   input  logic [SIDE_W-1:0]   side_i,
   input  logic [2*W+1:0]      fd_i,
   input  logic [2*W+1:0]      tr_i,
   input  logic [FRAC_W-1:0]   tq_i,
   input  logic [2*W+1:0]      sr_i,
   input  logic [FRAC_W-1:0]   sq_i,
   input  logic [2*W:0]        qn_i,
   input  logic [W-1:0]        qr_i,
   input  logic [W-1:0]        qq_i,
   input  logic [W-1:0]        qd_i,
   output logic                valid_o,
   output logic [SIDE_W-1:0]   side_o,
   output logic [2*W+1:0]      fd_o,
   output logic [2*W+1:0]      tr_o,
   output logic [FRAC_W-1:0]   tq_o,
   output logic [2*W+1:0]      sr_o,
   output logic [FRAC_W-1:0]   sq_o,
   output logic [2*W:0]        qn_o,
   output logic [W-1:0]        qr_o,
   output logic [W-1:0]        qq_o,
   output logic [W-1:0]        qd_o
);

   localparam int DW = 2*W+2;
   localparam int NW = 2*W+1;

   logic              valid_ff;
   logic [SIDE_W-1:0] side_ff;
   logic [DW-1:0]     fd_ff, tr_ff, sr_ff;
   logic [FRAC_W-1:0] tq_ff, sq_ff;
   logic [NW-1:0]     qn_ff;
   logic [W-1:0]      qr_ff, qq_ff, qd_ff;

   logic [DW-1:0]     tr_in, sr_in;
   logic [FRAC_W-1:0] tq_in, sq_in;
   logic [W:0]        qsh;
   logic              qge;
   logic [W-1:0]      qr_in;

   generate
      if (IDX < PARAM_SHIFT) begin : g_frac
         logic [DW:0] tsh, ssh;
         logic        tge, sge;
         always_comb begin
            tsh   = {tr_i, 1'b0};
            ssh   = {sr_i, 1'b0};
            tge   = tsh >= {1'b0, fd_i};
            sge   = ssh >= {1'b0, fd_i};
            tr_in = tge ? DW'(tsh - {1'b0, fd_i}) : DW'(tsh);
            sr_in = sge ? DW'(ssh - {1'b0, fd_i}) : DW'(ssh);
            tq_in = {tq_i[FRAC_W-2:0], tge};
            sq_in = {sq_i[FRAC_W-2:0], sge};
         end
      end else begin : g_hold
         always_comb begin
            tr_in = tr_i;
            sr_in = sr_i;
            tq_in = tq_i;
            sq_in = sq_i;
         end
      end
   endgenerate

   always_comb begin
      qsh   = {qr_i, qn_i[NW-1]};
      qge   = qsh >= {1'b0, qd_i};
      qr_in = qge ? W'(qsh - {1'b0, qd_i}) : W'(qsh);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
      side_ff <= side_i;
      fd_ff   <= fd_i;
      tr_ff   <= tr_in;
      sr_ff   <= sr_in;
      tq_ff   <= tq_in;
      sq_ff   <= sq_in;
      qn_ff   <= {qn_i[NW-2:0], 1'b0};
      qr_ff   <= qr_in;
      qq_ff   <= {qq_i[W-2:0], qge};
      qd_ff   <= qd_i;
   end

   assign valid_o = valid_ff;
   assign side_o  = side_ff;
   assign fd_o    = fd_ff;
   assign tr_o    = tr_ff;
   assign tq_o    = tq_ff;
   assign sr_o    = sr_ff;
   assign sq_o    = sq_ff;
   assign qn_o    = qn_ff;
   assign qr_o    = qr_ff;
   assign qq_o    = qq_ff;
   assign qd_o    = qd_ff;

endmodule

// File: rtl/segment_intersection_point.sv
// Top level of the segment intersection block: front pipeline, chain of
// divider cells and output stage. Depends on segip_pkg and segip_cell.
//
//   channel   ports                        transfer
//   request   start, busy, req_*           start high and busy low at the edge
//   response  rsp_valid, rsp_*             one cycle strobe, always taken
//   csr       csr_we, csr_index, csr_wdata write at the edge with csr_we high
//
// One item enters per cycle; busy stays low.
// The pipeline has nine front stages, one divider cell per
// bit of the collinear quotient dividend, and two output stages.
// Reset clears all valid flags and sets the tolerances to one.
// The receiver cannot stall; every result is shown for one cycle.
module segment_intersection_point
   import segip_pkg::*;
#(
   parameter int COORD_WIDTH = 32
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_first_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_first_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_first_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_first_end_y,
   input  logic signed [COORD_WIDTH-1:0] req_second_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_second_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_second_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_second_end_y,
   input  logic                          req_closed,
   output logic                          rsp_valid,
   output logic                          rsp_found,
   output logic [1:0]                    rsp_kind,
   output logic signed [COORD_WIDTH-1:0] rsp_point_x,
   output logic signed [COORD_WIDTH-1:0] rsp_point_y,
   input  logic                          csr_we,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata
);

   localparam int W  = COORD_WIDTH;
   localparam int PW = 2*W+2;
   localparam int CW = 2*W+3;
   localparam int DW = 2*W+2;
   localparam int NW = 2*W+1;
   localparam int NS = 2*W+1;
   localparam int LW = W+FRAC_W+2;
   localparam logic [FRAC_W-1:0] ONE_Q  = FRAC_W'(1) << PARAM_SHIFT;
   localparam logic [LW-1:0]     HALF_Q = LW'(1) << (PARAM_SHIFT-1);

   typedef struct packed {
      logic                cl;
      logic [1:0]          kind;
      logic                vert;
      logic signed [W-1:0] x1;
      logic signed [W-1:0] y1;
      logic signed [W:0]   dx12;
      logic signed [W:0]   dy12;
      logic signed [W-1:0] m;
      logic                qneg;
      logic                qzero;
   } side_type;

   localparam int SIDE_W = $bits(side_type);

   // configuration
   logic [31:0] cross_tol_ff;
   logic [15:0] coord_tol_ff;
   logic [15:0] param_tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cross_tol_ff <= 32'd1;
         coord_tol_ff <= 16'd1;
         param_tol_ff <= 16'd1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CROSS_TOL: cross_tol_ff <= csr_wdata;
            CSR_COORD_TOL: coord_tol_ff <= csr_wdata[15:0];
            CSR_PARAM_TOL: param_tol_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // stage 1: capture
   logic                s1_v_ff, s1_cl_ff;
   logic signed [W-1:0] s1_x1_ff, s1_y1_ff, s1_x2_ff, s1_y2_ff;
   logic signed [W-1:0] s1_x3_ff, s1_y3_ff, s1_x4_ff, s1_y4_ff;

   // stage 2: differences
   logic                s2_v_ff, s2_cl_ff;
   logic signed [W-1:0] s2_x1_ff, s2_y1_ff, s2_x2_ff, s2_y2_ff;
   logic signed [W-1:0] s2_x3_ff, s2_y3_ff, s2_x4_ff, s2_y4_ff;
   logic signed [W:0]   s2_dx12_ff, s2_dy12_ff, s2_dx34_ff, s2_dy34_ff;
   logic signed [W:0]   s2_dx13_ff, s2_dy13_ff;

   // stage 3: products
   logic                s3_v_ff, s3_cl_ff;
   logic signed [W-1:0] s3_x1_ff, s3_y1_ff, s3_x2_ff, s3_y2_ff;
   logic signed [W-1:0] s3_x3_ff, s3_y3_ff, s3_x4_ff, s3_y4_ff;
   logic signed [W:0]   s3_dx12_ff, s3_dy12_ff;
   logic signed [PW-1:0] s3_p1_ff, s3_p2_ff, s3_p3_ff, s3_p4_ff, s3_p5_ff, s3_p6_ff;

   // stage 4: cross products, axis choice
   logic                s4_v_ff, s4_cl_ff, s4_vert_ff;
   logic signed [W-1:0] s4_x1_ff, s4_y1_ff;
   logic signed [W:0]   s4_dx12_ff, s4_dy12_ff;
   logic signed [CW-1:0] s4_d_ff, s4_t_ff, s4_s_ff;
   logic signed [W-1:0] s4_a1_ff, s4_a2_ff, s4_b1_ff, s4_b2_ff;

   // stage 5: tolerance tests, normalized sign, ranges
   logic                s5_v_ff, s5_cl_ff, s5_vert_ff, s5_par_ff, s5_colt_ff;
   logic signed [W-1:0] s5_x1_ff, s5_y1_ff;
   logic signed [W:0]   s5_dx12_ff, s5_dy12_ff;
   logic signed [CW-1:0] s5_d_ff, s5_t_ff, s5_s_ff;
   logic signed [W-1:0] s5_hi1_ff, s5_lo1_ff, s5_hi2_ff, s5_lo2_ff;

   // stages 6 to 9
   logic                s6_v_ff, s7_v_ff, s8_v_ff, s9_v_ff;
   side_type            s6_sd_ff, s7_sd_ff, s8_sd_ff, s9_sd_ff;
   logic [DW-1:0]       s6_fd_ff, s6_tr_ff, s6_sr_ff, s7_fd_ff, s7_tr_ff, s7_sr_ff;
   logic [DW-1:0]       s8_fd_ff, s8_tr_ff, s8_sr_ff, s9_fd_ff, s9_tr_ff, s9_sr_ff;
   logic                s6_tq_ff, s6_sq_ff, s7_tq_ff, s7_sq_ff, s8_tq_ff, s8_sq_ff;
   logic                s9_tq_ff, s9_sq_ff;
   logic signed [W:0]   s7_mx_ff, s7_nd_ff;
   logic [W-1:0]        s7_mden_ff, s8_mden_ff, s9_mden_ff;
   logic signed [PW-1:0] s8_num_ff;
   logic [NW-1:0]       s9_qn_ff;

   logic [CW-1:0]       abs_d, abs_t;
   logic [W:0]          abs_dx12;
   logic                dneg;
   logic signed [W:0]   gap1, gap2;
   logic [W:0]          agap1, agap2;
   logic                disjoint, gap_hit, ov, inr, tge0, sge0, par_in;
   logic signed [W-1:0] min_hi, max_lo, m_in;
   logic [DW-1:0]       dnu, tnu, snu;
   logic [1:0]          kind_in;
   logic [PW-1:0]       abs_num;
   side_type            sd6_in, sd8_in, sd9_in;

   always_comb begin
      abs_d    = s4_d_ff[CW-1] ? CW'(-s4_d_ff) : CW'(s4_d_ff);
      abs_t    = s4_t_ff[CW-1] ? CW'(-s4_t_ff) : CW'(s4_t_ff);
      abs_dx12 = s3_dx12_ff[W] ? (W+1)'(-s3_dx12_ff) : (W+1)'(s3_dx12_ff);
      dneg     = s4_d_ff[CW-1];
      par_in   = (s4_d_ff == '0) || (abs_d < CW'(cross_tol_ff));

      disjoint = (s5_hi1_ff < s5_lo2_ff) || (s5_lo1_ff > s5_hi2_ff);
      gap1     = $signed({s5_hi1_ff[W-1], s5_hi1_ff}) - $signed({s5_lo2_ff[W-1], s5_lo2_ff});
      gap2     = $signed({s5_lo1_ff[W-1], s5_lo1_ff}) - $signed({s5_hi2_ff[W-1], s5_hi2_ff});
      agap1    = gap1[W] ? (W+1)'(-gap1) : (W+1)'(gap1);
      agap2    = gap2[W] ? (W+1)'(-gap2) : (W+1)'(gap2);
      gap_hit  = (agap1 < (W+1)'(coord_tol_ff)) || (agap2 < (W+1)'(coord_tol_ff));
      ov       = !disjoint && (s5_cl_ff || !gap_hit);
      min_hi   = (s5_hi1_ff < s5_hi2_ff) ? s5_hi1_ff : s5_hi2_ff;
      max_lo   = (s5_lo1_ff > s5_lo2_ff) ? s5_lo1_ff : s5_lo2_ff;
      m_in     = (min_hi > max_lo) ? min_hi : max_lo;
      inr      = !s5_t_ff[CW-1] && !s5_s_ff[CW-1] && (s5_t_ff <= s5_d_ff)
                 && (s5_s_ff <= s5_d_ff);
      dnu      = s5_d_ff[DW-1:0];
      tnu      = s5_t_ff[DW-1:0];
      snu      = s5_s_ff[DW-1:0];
      tge0     = tnu >= dnu;
      sge0     = snu >= dnu;
      if (s5_par_ff) begin
         kind_in = (s5_colt_ff && ov) ? KIND_COLLINEAR : KIND_NONE;
      end else begin
         kind_in = inr ? KIND_CROSS : KIND_NONE;
      end

      sd6_in.cl    = s5_cl_ff;
      sd6_in.kind  = kind_in;
      sd6_in.vert  = s5_vert_ff;
      sd6_in.x1    = s5_x1_ff;
      sd6_in.y1    = s5_y1_ff;
      sd6_in.dx12  = s5_dx12_ff;
      sd6_in.dy12  = s5_dy12_ff;
      sd6_in.m     = m_in;
      sd6_in.qneg  = 1'b0;
      sd6_in.qzero = 1'b0;

      abs_num  = s8_num_ff[PW-1] ? PW'(-s8_num_ff) : PW'(s8_num_ff);
      sd8_in   = s7_sd_ff;
      sd8_in.qneg  = 1'b0;
      sd8_in.qzero = (s7_mden_ff == '0);

      sd9_in      = s8_sd_ff;
      sd9_in.qneg = s8_num_ff[PW-1] != (!s8_sd_ff.dx12[W] && (s8_sd_ff.dx12 != '0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
         s6_v_ff <= 1'b0;
         s7_v_ff <= 1'b0;
         s8_v_ff <= 1'b0;
         s9_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= start && !busy;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
         s6_v_ff <= s5_v_ff;
         s7_v_ff <= s6_v_ff;
         s8_v_ff <= s7_v_ff;
         s9_v_ff <= s8_v_ff;
      end

      s1_cl_ff <= req_closed;
      s1_x1_ff <= req_first_start_x;
      s1_y1_ff <= req_first_start_y;
      s1_x2_ff <= req_first_end_x;
      s1_y2_ff <= req_first_end_y;
      s1_x3_ff <= req_second_start_x;
      s1_y3_ff <= req_second_start_y;
      s1_x4_ff <= req_second_end_x;
      s1_y4_ff <= req_second_end_y;

      s2_cl_ff <= s1_cl_ff;
      s2_x1_ff <= s1_x1_ff;
      s2_y1_ff <= s1_y1_ff;
      s2_x2_ff <= s1_x2_ff;
      s2_y2_ff <= s1_y2_ff;
      s2_x3_ff <= s1_x3_ff;
      s2_y3_ff <= s1_y3_ff;
      s2_x4_ff <= s1_x4_ff;
      s2_y4_ff <= s1_y4_ff;
      s2_dx12_ff <= $signed({s1_x2_ff[W-1], s1_x2_ff}) - $signed({s1_x1_ff[W-1], s1_x1_ff});
      s2_dy12_ff <= $signed({s1_y2_ff[W-1], s1_y2_ff}) - $signed({s1_y1_ff[W-1], s1_y1_ff});
      s2_dx34_ff <= $signed({s1_x4_ff[W-1], s1_x4_ff}) - $signed({s1_x3_ff[W-1], s1_x3_ff});
      s2_dy34_ff <= $signed({s1_y4_ff[W-1], s1_y4_ff}) - $signed({s1_y3_ff[W-1], s1_y3_ff});
      s2_dx13_ff <= $signed({s1_x1_ff[W-1], s1_x1_ff}) - $signed({s1_x3_ff[W-1], s1_x3_ff});
      s2_dy13_ff <= $signed({s1_y1_ff[W-1], s1_y1_ff}) - $signed({s1_y3_ff[W-1], s1_y3_ff});

      s3_cl_ff <= s2_cl_ff;
      s3_x1_ff <= s2_x1_ff;
      s3_y1_ff <= s2_y1_ff;
      s3_x2_ff <= s2_x2_ff;
      s3_y2_ff <= s2_y2_ff;
      s3_x3_ff <= s2_x3_ff;
      s3_y3_ff <= s2_y3_ff;
      s3_x4_ff <= s2_x4_ff;
      s3_y4_ff <= s2_y4_ff;
      s3_dx12_ff <= s2_dx12_ff;
      s3_dy12_ff <= s2_dy12_ff;
      s3_p1_ff <= PW'(s2_dy34_ff * s2_dx12_ff);
      s3_p2_ff <= PW'(s2_dx34_ff * s2_dy12_ff);
      s3_p3_ff <= PW'(s2_dx34_ff * s2_dy13_ff);
      s3_p4_ff <= PW'(s2_dy34_ff * s2_dx13_ff);
      s3_p5_ff <= PW'(s2_dx12_ff * s2_dy13_ff);
      s3_p6_ff <= PW'(s2_dy12_ff * s2_dx13_ff);

      s4_cl_ff   <= s3_cl_ff;
      s4_x1_ff   <= s3_x1_ff;
      s4_y1_ff   <= s3_y1_ff;
      s4_dx12_ff <= s3_dx12_ff;
      s4_dy12_ff <= s3_dy12_ff;
      s4_d_ff <= $signed({s3_p1_ff[PW-1], s3_p1_ff}) - $signed({s3_p2_ff[PW-1], s3_p2_ff});
      s4_t_ff <= $signed({s3_p3_ff[PW-1], s3_p3_ff}) - $signed({s3_p4_ff[PW-1], s3_p4_ff});
      s4_s_ff <= $signed({s3_p5_ff[PW-1], s3_p5_ff}) - $signed({s3_p6_ff[PW-1], s3_p6_ff});
      s4_vert_ff <= abs_dx12 < (W+1)'(coord_tol_ff);
      if (abs_dx12 < (W+1)'(coord_tol_ff)) begin
         s4_a1_ff <= s3_y1_ff;
         s4_a2_ff <= s3_y2_ff;
         s4_b1_ff <= s3_y3_ff;
         s4_b2_ff <= s3_y4_ff;
      end else begin
         s4_a1_ff <= s3_x1_ff;
         s4_a2_ff <= s3_x2_ff;
         s4_b1_ff <= s3_x3_ff;
         s4_b2_ff <= s3_x4_ff;
      end

      s5_cl_ff   <= s4_cl_ff;
      s5_vert_ff <= s4_vert_ff;
      s5_x1_ff   <= s4_x1_ff;
      s5_y1_ff   <= s4_y1_ff;
      s5_dx12_ff <= s4_dx12_ff;
      s5_dy12_ff <= s4_dy12_ff;
      s5_par_ff  <= par_in;
      s5_colt_ff <= abs_t < CW'(cross_tol_ff);
      s5_d_ff    <= dneg ? -s4_d_ff : s4_d_ff;
      s5_t_ff    <= dneg ? -s4_t_ff : s4_t_ff;
      s5_s_ff    <= dneg ? -s4_s_ff : s4_s_ff;
      s5_hi1_ff  <= (s4_a1_ff > s4_a2_ff) ? s4_a1_ff : s4_a2_ff;
      s5_lo1_ff  <= (s4_a1_ff > s4_a2_ff) ? s4_a2_ff : s4_a1_ff;
      s5_hi2_ff  <= (s4_b1_ff > s4_b2_ff) ? s4_b1_ff : s4_b2_ff;
      s5_lo2_ff  <= (s4_b1_ff > s4_b2_ff) ? s4_b2_ff : s4_b1_ff;

      s6_sd_ff <= sd6_in;
      s6_fd_ff <= dnu;
      s6_tr_ff <= tge0 ? DW'(tnu - dnu) : tnu;
      s6_sr_ff <= sge0 ? DW'(snu - dnu) : snu;
      s6_tq_ff <= tge0;
      s6_sq_ff <= sge0;

      s7_sd_ff   <= s6_sd_ff;
      s7_fd_ff   <= s6_fd_ff;
      s7_tr_ff   <= s6_tr_ff;
      s7_sr_ff   <= s6_sr_ff;
      s7_tq_ff   <= s6_tq_ff;
      s7_sq_ff   <= s6_sq_ff;
      s7_mx_ff   <= $signed({s6_sd_ff.m[W-1], s6_sd_ff.m})
                    - $signed({s6_sd_ff.x1[W-1], s6_sd_ff.x1});
      s7_nd_ff   <= -s6_sd_ff.dy12;
      s7_mden_ff <= s6_sd_ff.dx12[W] ? W'(-s6_sd_ff.dx12) : W'(s6_sd_ff.dx12);

      s8_sd_ff   <= sd8_in;
      s8_fd_ff   <= s7_fd_ff;
      s8_tr_ff   <= s7_tr_ff;
      s8_sr_ff   <= s7_sr_ff;
      s8_tq_ff   <= s7_tq_ff;
      s8_sq_ff   <= s7_sq_ff;
      s8_mden_ff <= s7_mden_ff;
      s8_num_ff  <= PW'(s7_nd_ff * s7_mx_ff);

      s9_sd_ff   <= sd9_in;
      s9_fd_ff   <= s8_fd_ff;
      s9_tr_ff   <= s8_tr_ff;
      s9_sr_ff   <= s8_sr_ff;
      s9_tq_ff   <= s8_tq_ff;
      s9_sq_ff   <= s8_sq_ff;
      s9_mden_ff <= s8_mden_ff;
      s9_qn_ff   <= NW'(abs_num + PW'(s8_mden_ff >> 1));
   end

   // divider chain
   logic              c_v    [NS+1];
   logic [SIDE_W-1:0] c_side [NS+1];
   logic [DW-1:0]     c_fd   [NS+1];
   logic [DW-1:0]     c_tr   [NS+1];
   logic [FRAC_W-1:0] c_tq   [NS+1];
   logic [DW-1:0]     c_sr   [NS+1];
   logic [FRAC_W-1:0] c_sq   [NS+1];
   logic [NW-1:0]     c_qn   [NS+1];
   logic [W-1:0]      c_qr   [NS+1];
   logic [W-1:0]      c_qq   [NS+1];
   logic [W-1:0]      c_qd   [NS+1];

   assign c_v[0]    = s9_v_ff;
   assign c_side[0] = s9_sd_ff;
   assign c_fd[0]   = s9_fd_ff;
   assign c_tr[0]   = s9_tr_ff;
   assign c_tq[0]   = FRAC_W'(s9_tq_ff);
   assign c_sr[0]   = s9_sr_ff;
   assign c_sq[0]   = FRAC_W'(s9_sq_ff);
   assign c_qn[0]   = s9_qn_ff;
   assign c_qr[0]   = '0;
   assign c_qq[0]   = '0;
   assign c_qd[0]   = s9_mden_ff;

   generate
      for (genvar k = 0; k < NS; k++) begin : g_cell
         segip_cell #(.W(W), .IDX(k), .SIDE_W(SIDE_W)) u_cell (
            .clock   (clock),
            .reset   (reset),
            .valid_i (c_v[k]),
            .side_i  (c_side[k]),
            .fd_i    (c_fd[k]),
            .tr_i    (c_tr[k]),
            .tq_i    (c_tq[k]),
            .sr_i    (c_sr[k]),
            .sq_i    (c_sq[k]),
            .qn_i    (c_qn[k]),
            .qr_i    (c_qr[k]),
            .qq_i    (c_qq[k]),
            .qd_i    (c_qd[k]),
            .valid_o (c_v[k+1]),
            .side_o  (c_side[k+1]),
            .fd_o    (c_fd[k+1]),
            .tr_o    (c_tr[k+1]),
            .tq_o    (c_tq[k+1]),
            .sr_o    (c_sr[k+1]),
            .sq_o    (c_sq[k+1]),
            .qn_o    (c_qn[k+1]),
            .qr_o    (c_qr[k+1]),
            .qq_o    (c_qq[k+1]),
            .qd_o    (c_qd[k+1])
         );
      end
   endgenerate

   // final stages
   side_type            sd_n;
   logic [FRAC_W-1:0]   tq_n, sq_n;
   logic                near_t, near_s;
   logic [1:0]          kind_f;
   logic [W-1:0]        qv;

   always_comb begin
      sd_n   = c_side[NS];
      tq_n   = c_tq[NS];
      sq_n   = c_sq[NS];
      near_t = (tq_n < FRAC_W'(param_tol_ff)) || (FRAC_W'(ONE_Q - tq_n) < FRAC_W'(param_tol_ff));
      near_s = (sq_n < FRAC_W'(param_tol_ff)) || (FRAC_W'(ONE_Q - sq_n) < FRAC_W'(param_tol_ff));
      if (sd_n.kind == KIND_CROSS) begin
         kind_f = (sd_n.cl || (!near_t && !near_s)) ? KIND_CROSS : KIND_NONE;
      end else begin
         kind_f = sd_n.kind;
      end
      if (sd_n.qzero) begin
         qv = '0;
      end else begin
         qv = sd_n.qneg ? W'(-c_qq[NS]) : c_qq[NS];
      end
   end

   logic                f1_v_ff, f1_vert_ff;
   logic [1:0]          f1_kind_ff;
   logic signed [W-1:0] f1_x1_ff, f1_y1_ff, f1_m_ff;
   logic [W-1:0]        f1_qv_ff;
   logic signed [LW-1:0] f1_px_ff, f1_py_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
      end else begin
         f1_v_ff <= c_v[NS];
      end
      f1_kind_ff <= kind_f;
      f1_vert_ff <= sd_n.vert;
      f1_x1_ff   <= sd_n.x1;
      f1_y1_ff   <= sd_n.y1;
      f1_m_ff    <= sd_n.m;
      f1_qv_ff   <= qv;
      f1_px_ff   <= LW'($signed({1'b0, tq_n}) * sd_n.dx12);
      f1_py_ff   <= LW'($signed({1'b0, tq_n}) * sd_n.dy12);
   end

   logic [LW-1:0] lsum_x, lsum_y;
   logic [W-1:0]  cx_in, cy_in;

   always_comb begin
      lsum_x = f1_px_ff + HALF_Q;
      lsum_y = f1_py_ff + HALF_Q;
      cx_in  = W'(f1_x1_ff + lsum_x[PARAM_SHIFT +: W]);
      cy_in  = W'(f1_y1_ff + lsum_y[PARAM_SHIFT +: W]);
   end

   logic                rsp_valid_ff, rsp_found_ff;
   logic [1:0]          rsp_kind_ff;
   logic signed [W-1:0] rsp_x_ff, rsp_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rsp_found_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= f1_v_ff;
         rsp_found_ff <= f1_v_ff && (f1_kind_ff != KIND_NONE);
      end
      rsp_kind_ff <= f1_kind_ff;
      case (f1_kind_ff)
         KIND_CROSS: begin
            rsp_x_ff <= cx_in;
            rsp_y_ff <= cy_in;
         end
         KIND_COLLINEAR: begin
            if (f1_vert_ff) begin
               rsp_x_ff <= f1_x1_ff;
               rsp_y_ff <= f1_m_ff;
            end else begin
               rsp_x_ff <= f1_m_ff;
               rsp_y_ff <= W'(f1_y1_ff + f1_qv_ff);
            end
         end
         default: begin
            rsp_x_ff <= '0;
            rsp_y_ff <= '0;
         end
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_found   = rsp_found_ff;
   assign rsp_kind    = rsp_kind_ff;
   assign rsp_point_x = rsp_x_ff;
   assign rsp_point_y = rsp_y_ff;

   a_found_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_found == (rsp_kind != KIND_NONE)))
      else $error("found disagrees with kind");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_point_x == '0 && rsp_point_y == '0))
      else $error("point not cleared on miss");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !rsp_found))
      else $error("result after reset");

   a_found_valid: assert property (@(posedge clock)
      rsp_found |-> rsp_valid)
      else $error("found without strobe");

endmodule
